[hdl/rotscl_pkg.sv]
// shared constants and tables for the rotate and scale point pipeline
package rotscl_pkg;

   localparam int GUARD_BITS  = 14;
   localparam int SCALE_FRAC  = 12;
   localparam int ANGLE_BITS  = 16;
   localparam int SCALE_BITS  = 16;
   localparam int Z_BITS      = 32;
   localparam int MAX_STAGES  = 24;
   localparam int FIN_DEPTH   = 5;
   localparam int PROD_SPLIT  = 24;
   localparam int CSR_ADDR_BITS = 3;
   localparam int CSR_DATA_BITS = 32;

   // register index, taken from the word address bit
   localparam logic REG_ANGLE = 1'b0;
   localparam logic REG_SCALE = 1'b1;

   localparam logic [ANGLE_BITS-1:0] ANGLE_RESET = 16'd0;
   localparam logic [SCALE_BITS-1:0] SCALE_RESET = 16'd4096;

   // cordic gain 1/1.6467..., unsigned q0.32
   localparam logic [31:0] GAIN_Q32 = 32'd2608131496;

   // atan(2^-i), 2^32 units per turn
   localparam logic [Z_BITS-1:0] ATAN_TABLE [0:MAX_STAGES-1] = '{
      32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
      32'd42667331,  32'd21354465,  32'd10679838,  32'd5340245,
      32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
      32'd166886,    32'd83443,     32'd41722,     32'd20861,
      32'd10430,     32'd5215,      32'd2608,      32'd1304,
      32'd652,       32'd326,       32'd163,       32'd81
   };

endpackage

[hdl/rotscl_cell.sv]
// one cordic micro-rotation cell of the rotation chain
module rotscl_cell import rotscl_pkg::*; #(
   parameter int XW  = 33,
   parameter int IDX = 0
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     enable,
   input  logic                     prev_valid,
   input  logic signed [XW-1:0]     prev_x,
   input  logic signed [XW-1:0]     prev_y,
   input  logic signed [Z_BITS-1:0] prev_z,
   output logic                     next_valid,
   output logic signed [XW-1:0]     next_x,
   output logic signed [XW-1:0]     next_y,
   output logic signed [Z_BITS-1:0] next_z
);

   logic                     valid_ff;
   logic signed [XW-1:0]     x_ff, x_in;
   logic signed [XW-1:0]     y_ff, y_in;
   logic signed [Z_BITS-1:0] z_ff, z_in;
   logic signed [XW-1:0]     shift_x;
   logic signed [XW-1:0]     shift_y;
   logic signed [Z_BITS-1:0] step;
   logic                     turn_ccw;

   assign shift_x  = prev_y >>> IDX;
   assign shift_y  = prev_x >>> IDX;
   assign step     = signed'(ATAN_TABLE[IDX]);
   assign turn_ccw = !prev_z[Z_BITS-1];

   always_comb begin
      if (turn_ccw) begin
         x_in = prev_x - shift_x;
         y_in = prev_y + shift_y;
         z_in = prev_z - step;
      end else begin
         x_in = prev_x + shift_x;
         y_in = prev_y - shift_y;
         z_in = prev_z + step;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (enable) begin
         valid_ff <= prev_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         x_ff <= x_in;
         y_ff <= y_in;
         z_ff <= z_in;
      end
   end

   assign next_valid = valid_ff;
   assign next_x     = x_ff;
   assign next_y     = y_ff;
   assign next_z     = z_ff;

endmodule

[hdl/rotscl_finish.sv]
// gain correction, scaling, rounding and saturation of one coordinate
module rotscl_finish import rotscl_pkg::*; #(
   parameter int CB = 16,
   parameter int XW = 33
) (
   input  logic                  clock,
   input  logic                  enable,
   input  logic signed [XW-1:0]  coord,
   input  logic [SCALE_BITS-1:0] scale,
   output logic [CB-1:0]         result,
   output logic                  clip
);

   localparam int LO  = PROD_SPLIT;
   localparam int HW  = XW - LO;
   localparam int PLW = LO + 32;
   localparam int PHW = HW + 32;
   localparam int FW  = XW + 32;
   localparam int PW  = XW + SCALE_BITS;
   localparam int FB  = GUARD_BITS + SCALE_FRAC;
   localparam int NW  = PW + 1 - FB;
   localparam logic [PW:0]    HALF    = (PW+1)'(1) << (FB - 1);
   localparam logic [NW-1:0]  LIM     = NW'(1) << (CB - 1);
   localparam logic [NW-1:0]  LIM_M1  = LIM - NW'(1);
   localparam logic [CB-1:0]  MAX_OUT = {1'b0, {(CB-1){1'b1}}};
   localparam logic [CB-1:0]  MIN_OUT = {1'b1, {(CB-1){1'b0}}};

   // stage 1: magnitude
   logic           neg1_ff;
   logic [XW-1:0]  mag_ff, mag_in;
   // stage 2: split gain products
   logic           neg2_ff;
   logic [PLW-1:0] plo_ff, plo_in;
   logic [PHW-1:0] phi_ff, phi_in;
   // stage 3: gain-corrected magnitude
   logic           neg3_ff;
   logic [FW-1:0]  full;
   logic [XW-1:0]  gain_ff, gain_in;
   // stage 4: scaled magnitude
   logic           neg4_ff;
   logic [PW-1:0]  prod_ff, prod_in;
   // stage 5: rounded and saturated
   logic [PW:0]    biased;
   logic           under;
   logic [NW-1:0]  mag_round;
   logic           clip_in;
   logic [CB-1:0]  result_ff, result_in;
   logic           clip_ff;

   assign mag_in  = coord[XW-1] ? (~unsigned'(coord) + XW'(1)) : unsigned'(coord);
   assign plo_in  = PLW'(mag_ff[LO-1:0]) * PLW'(GAIN_Q32);
   assign phi_in  = PHW'(mag_ff[XW-1:LO]) * PHW'(GAIN_Q32);
   assign full    = {phi_ff, {LO{1'b0}}} + FW'(plo_ff);
   assign gain_in = full[FW-1:32];
   assign prod_in = PW'(gain_ff) * PW'(scale);

   // negative values round half toward zero, positive ones half away
   assign biased    = neg4_ff ? ({1'b0, prod_ff} - HALF) : ({1'b0, prod_ff} + HALF);
   assign under     = neg4_ff && ({1'b0, prod_ff} < HALF);
   assign mag_round = under ? '0 : biased[PW:FB];
   assign clip_in   = neg4_ff ? (mag_round > LIM) : (mag_round > LIM_M1);

   always_comb begin
      if (clip_in) begin
         result_in = neg4_ff ? MIN_OUT : MAX_OUT;
      end else if (neg4_ff) begin
         result_in = CB'(0) - mag_round[CB-1:0];
      end else begin
         result_in = mag_round[CB-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         neg1_ff   <= coord[XW-1];
         mag_ff    <= mag_in;
         neg2_ff   <= neg1_ff;
         plo_ff    <= plo_in;
         phi_ff    <= phi_in;
         neg3_ff   <= neg2_ff;
         gain_ff   <= gain_in;
         neg4_ff   <= neg3_ff;
         prod_ff   <= prod_in;
         result_ff <= result_in;
         clip_ff   <= clip_in;
      end
   end

   assign result = result_ff;
   assign clip   = clip_ff;

endmodule

[hdl/rotate_scale_point.sv]
// top level: rotate a point by the configured angle and scale it, fully pipelined
//
// usage
// - req channel: one point per item, tdata = {point_y, point_x}; one item can be
//   taken every cycle while the skid register is empty
// - rsp channel: one moved point per item, tdata = {moved_y, moved_x}, tuser =
//   clipped; items leave in the order they came in
// - csr port: apb-style, rotation_angle at 0x0, scale_factor at 0x4; write only
//   while no item is in flight
// - pipeline: one input stage, one per cordic cell, five in the gain/scale/round
//   path
// - throughput: one item per cycle while the skid register is empty, set by the
//   unrolled cell chain; every cell and every finish stage holds its own item
// - reset clears all valid bits and loads angle 0 and scale 1.0; the pipe is
//   empty and req_tready is high the cycle after
// - when the receiver stalls, the item at the end moves into a skid register
//   and the pipe freezes the next cycle; req_tready drops only while the skid
//   register is full
module rotate_scale_point import rotscl_pkg::*; #(
   parameter int COORD_BITS    = 16,
   parameter int CORDIC_STAGES = 18
) (
   input  logic                           clock,
   input  logic                           reset,
   // req: point_x, point_y, zero pad
   input  logic                           req_tvalid,
   output logic                           req_tready,
   input  logic [((2*COORD_BITS+7)/8)*8-1:0] req_tdata,
   // rsp: moved_x, moved_y, zero pad
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   output logic [((2*COORD_BITS+7)/8)*8-1:0] rsp_tdata,
   // rsp: clipped
   output logic                           rsp_tuser,
   input  logic                           csr_psel,
   input  logic                           csr_penable,
   input  logic                           csr_pwrite,
   input  logic [CSR_ADDR_BITS-1:0]       csr_paddr,
   input  logic [CSR_DATA_BITS-1:0]       csr_pwdata,
   output logic [CSR_DATA_BITS-1:0]       csr_prdata,
   output logic                           csr_pready
);

   localparam int CB     = COORD_BITS;
   localparam int DW     = ((2*CB+7)/8)*8;
   localparam int XW     = CB + GUARD_BITS + 3;
   localparam int NCELL  = (CORDIC_STAGES > MAX_STAGES) ? MAX_STAGES : CORDIC_STAGES;
   localparam logic [1:0] QUAD_0   = 2'd0;
   localparam logic [1:0] QUAD_90  = 2'd1;
   localparam logic [1:0] QUAD_180 = 2'd2;
   localparam logic [1:0] QUAD_270 = 2'd3;

   // configuration registers
   logic [ANGLE_BITS-1:0] angle_ff;
   logic [SCALE_BITS-1:0] scale_ff;
   logic                  csr_write;

   // pipe control: everything advances while the skid register is empty
   logic pipe_run;

   // input stage: quarter-turn pre-rotation and residual angle
   logic signed [CB-1:0]     px;
   logic signed [CB-1:0]     py;
   logic signed [XW-1:0]     ext_x;
   logic signed [XW-1:0]     ext_y;
   logic signed [XW-1:0]     base_x;
   logic signed [XW-1:0]     base_y;
   logic [1:0]               quad;
   logic [ANGLE_BITS-1:0]    resid;
   logic                     in_valid_ff;
   logic signed [XW-1:0]     in_x_ff, in_x_in;
   logic signed [XW-1:0]     in_y_ff, in_y_in;
   logic signed [Z_BITS-1:0] in_z_ff, in_z_in;

   // cell chain taps
   logic                     chain_valid [0:NCELL];
   logic signed [XW-1:0]     chain_x     [0:NCELL];
   logic signed [XW-1:0]     chain_y     [0:NCELL];
   logic signed [Z_BITS-1:0] chain_z     [0:NCELL];

   // finish path
   logic [FIN_DEPTH-1:0] fin_valid_ff, fin_valid_in;
   logic [CB-1:0]        fin_x;
   logic [CB-1:0]        fin_y;
   logic                 fin_clip_x;
   logic                 fin_clip_y;

   // skid register at the output
   logic          skid_valid_ff, skid_valid_in;
   logic [CB-1:0] skid_x_ff;
   logic [CB-1:0] skid_y_ff;
   logic          skid_clip_ff;
   logic          last_valid;

   // ---------------- configuration port ----------------
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         angle_ff <= ANGLE_RESET;
         scale_ff <= SCALE_RESET;
      end else if (csr_write) begin
         if (csr_paddr[2] == REG_SCALE) begin
            scale_ff <= csr_pwdata[SCALE_BITS-1:0];
         end else begin
            angle_ff <= csr_pwdata[ANGLE_BITS-1:0];
         end
      end
   end

   assign csr_prdata = (csr_paddr[2] == REG_ANGLE) ? CSR_DATA_BITS'(angle_ff)
                                                   : CSR_DATA_BITS'(scale_ff);

   // ---------------- input stage ----------------
   assign pipe_run   = !skid_valid_ff;
   assign req_tready = pipe_run;

   assign px    = signed'(req_tdata[CB-1:0]);
   assign py    = signed'(req_tdata[2*CB-1:CB]);
   assign ext_x = XW'(px);
   assign ext_y = XW'(py);

   // nearest quarter turn, residual lies in one octant either side
   assign quad  = angle_ff[15:14] + {1'b0, angle_ff[13]};
   assign resid = {angle_ff[15:14] - quad, angle_ff[13:0]};

   always_comb begin
      case (quad)
         QUAD_0: begin
            base_x = ext_x;
            base_y = ext_y;
         end
         QUAD_90: begin
            base_x = -ext_y;
            base_y = ext_x;
         end
         QUAD_180: begin
            base_x = -ext_x;
            base_y = -ext_y;
         end
         QUAD_270: begin
            base_x = ext_y;
            base_y = -ext_x;
         end
         default: begin
            base_x = ext_x;
            base_y = ext_y;
         end
      endcase
   end

   assign in_x_in = base_x <<< GUARD_BITS;
   assign in_y_in = base_y <<< GUARD_BITS;
   // residual angle widened to 2^32 units per turn
   assign in_z_in = signed'({resid, {(Z_BITS-ANGLE_BITS){1'b0}}});

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (pipe_run) begin
         in_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (pipe_run) begin
         in_x_ff <= in_x_in;
         in_y_ff <= in_y_in;
         in_z_ff <= in_z_in;
      end
   end

   // ---------------- cordic cell chain ----------------
   assign chain_valid[0] = in_valid_ff;
   assign chain_x[0]     = in_x_ff;
   assign chain_y[0]     = in_y_ff;
   assign chain_z[0]     = in_z_ff;

   for (genvar gi = 0; gi < NCELL; gi++) begin : g_cell
      rotscl_cell #(
         .XW  (XW),
         .IDX (gi)
      ) u_cell (
         .clock      (clock),
         .reset      (reset),
         .enable     (pipe_run),
         .prev_valid (chain_valid[gi]),
         .prev_x     (chain_x[gi]),
         .prev_y     (chain_y[gi]),
         .prev_z     (chain_z[gi]),
         .next_valid (chain_valid[gi+1]),
         .next_x     (chain_x[gi+1]),
         .next_y     (chain_y[gi+1]),
         .next_z     (chain_z[gi+1])
      );
   end

   // ---------------- gain, scale, round ----------------
   rotscl_finish #(
      .CB (CB),
      .XW (XW)
   ) u_finish_x (
      .clock  (clock),
      .enable (pipe_run),
      .coord  (chain_x[NCELL]),
      .scale  (scale_ff),
      .result (fin_x),
      .clip   (fin_clip_x)
   );

   rotscl_finish #(
      .CB (CB),
      .XW (XW)
   ) u_finish_y (
      .clock  (clock),
      .enable (pipe_run),
      .coord  (chain_y[NCELL]),
      .scale  (scale_ff),
      .result (fin_y),
      .clip   (fin_clip_y)
   );

   // valid bits follow the finish stages
   assign fin_valid_in = {fin_valid_ff[FIN_DEPTH-2:0], chain_valid[NCELL]};
   assign last_valid   = fin_valid_ff[FIN_DEPTH-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         fin_valid_ff <= '0;
      end else if (pipe_run) begin
         fin_valid_ff <= fin_valid_in;
      end
   end

   // ---------------- output skid ----------------
   // a stalled item at the end is parked here while the pipe shifts once more
   always_comb begin
      if (skid_valid_ff) begin
         skid_valid_in = !rsp_tready;
      end else begin
         skid_valid_in = last_valid && !rsp_tready;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         skid_valid_ff <= 1'b0;
      end else begin
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (!skid_valid_ff) begin
         skid_x_ff    <= fin_x;
         skid_y_ff    <= fin_y;
         skid_clip_ff <= fin_clip_x || fin_clip_y;
      end
   end

   assign rsp_tvalid = skid_valid_ff || last_valid;
   assign rsp_tdata  = skid_valid_ff ? DW'({skid_y_ff, skid_x_ff}) : DW'({fin_y, fin_x});
   assign rsp_tuser  = skid_valid_ff ? skid_clip_ff : (fin_clip_x || fin_clip_y);

endmodule

[hdl/rotscl_checker.sv]
// port-level checks for the rotate and scale point block, bound to the top level
module rotscl_checker #(
   parameter int COORD_BITS = 16
) (
   input logic                                clock,
   input logic                                reset,
   input logic                                req_tready,
   input logic                                rsp_tvalid,
   input logic                                rsp_tready,
   input logic [((2*COORD_BITS+7)/8)*8-1:0]   rsp_tdata,
   input logic                                rsp_tuser
);

   localparam int CB = COORD_BITS;
   localparam logic [CB-1:0] MAX_OUT = {1'b0, {(CB-1){1'b1}}};
   localparam logic [CB-1:0] MIN_OUT = {1'b1, {(CB-1){1'b0}}};

   // pipe comes up empty
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result item shown right after reset");

   // a stalled result holds still
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("stalled result item changed");

   // the flag only comes with a coordinate pinned at a bound
   a_clip_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |->
         rsp_tdata[CB-1:0] == MAX_OUT || rsp_tdata[CB-1:0] == MIN_OUT ||
         rsp_tdata[2*CB-1:CB] == MAX_OUT || rsp_tdata[2*CB-1:CB] == MIN_OUT)
      else $error("clipped set without a saturated coordinate");

   // input backpressure only follows an output stall
   a_ready_cause: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> $past(rsp_tvalid && !rsp_tready))
      else $error("req_tready low without a stalled result");

   // req_tready is low only while a result item is shown
   a_ready_drop: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> rsp_tvalid)
      else $error("req_tready low with no result waiting");

endmodule

bind rotate_scale_point rotscl_checker #(
   .COORD_BITS (COORD_BITS)
) u_rotscl_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);
